// ===== hw/rtl/hpgs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV palette gradient shader package
// Payload types, register indexes, palette reset values and the divide by 255
// helper that the shader datapath uses.
// ----------------------------------------------------------------------------
package hpgs_pkg;

   localparam int PALETTE_SIZE = 6;
   localparam int CSR_INDEX_W  = 3;
   localparam int COLOR_W      = 24;
   localparam int MODE_W       = 3;

   // register indexes: palette entries sit at 0..5, mode right after them
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE = CSR_INDEX_W'(PALETTE_SIZE);

   // mode bits
   localparam int MODE_REVERSE = 0;
   localparam int MODE_MIRROR  = 1;
   localparam int MODE_RADIAL  = 2;

   localparam logic [10:0] PHASE_SPAN  = 11'd1536;
   localparam logic [10:0] PHASE_LAST  = 11'd1535;
   localparam logic [18:0] RADIAL_NUM  = 19'd1380;
   localparam logic [3:0]  SEG_WRAP    = 4'd6;
   localparam logic [2:0]  LAST_ENTRY  = 3'd5;

   // rainbow palette after reset
   localparam logic [COLOR_W-1:0] COLOR_RESET [PALETTE_SIZE] = '{
      24'h00FFFF, 24'h2BFFFF, 24'h55FFFF, 24'h80FFFF, 24'hABFFFF, 24'hD5FFFF
   };

   typedef struct packed {
      logic [7:0]  position;
      logic [10:0] phase;
   } req_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
   } rsp_type;

   // floor(x / 255), exact for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
      return t[15:8];
   endfunction

   // move a toward b by f/255 of the distance, quotient truncated
   function automatic logic [7:0] lerp_toward(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] f);
      logic [7:0] gap;
      logic [7:0] step;
      gap  = (b > a) ? (b - a) : (a - b);
      step = div255(16'(gap) * 16'(f));
      return (b > a) ? (a + step) : (a - step);
   endfunction

endpackage

// ===== hw/rtl/hsv_palette_gradient_shader_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV palette gradient shader
// Maps an LED position and an animation phase to a color blended between two
// adjacent entries of a six-entry HSV palette.
// ----------------------------------------------------------------------------
// One item is taken every clock: busy never rises, and the result of an item
// accepted is shown with rsp_strobe for a single cycle, after passing through an
// input register, one pass of blend logic and a result register.
// The receiver has no way to stall, so it must take every strobed beat.
// Registers are written through the csr port, which is always ready; write them
// only while no item is in flight. Index 0..5 are the palette entries (hue,
// saturation, value bytes from high to low), index 6 is the mode register,
// index 7 is ignored.
module hsv_palette_gradient_shader_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  hpgs_pkg::req_type                    req_data,
   output logic                                 rsp_strobe,
   output hpgs_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hpgs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hpgs_pkg::COLOR_W-1:0]         csr_wdata
);
   import hpgs_pkg::*;

   logic [COLOR_W-1:0] color_ff [PALETTE_SIZE];
   logic [MODE_W-1:0]  mode_ff;

   logic               in_valid_ff;
   req_type            in_data_ff;
   logic               out_valid_ff;
   rsp_type            out_data_ff;
   rsp_type            out_data_in;

   logic [10:0] phase_red;
   logic [10:0] phase_eff;
   logic [7:0]  pos_eff;
   logic [18:0] radial_prod;
   logic [10:0] scaled;
   logic [11:0] sum;
   logic [3:0]  seg;
   logic [2:0]  k1;
   logic [2:0]  k2;
   logic [7:0]  frac;
   logic [COLOR_W-1:0] e1;
   logic [COLOR_W-1:0] e2;
   logic [7:0]  h1, s1, v1, h2, s2, v2;
   logic [7:0]  h1_a, h2_a, h1_b, h2_b;
   logic [7:0]  hdiff;
   logic        hneg;
   logic [7:0]  hmag;
   logic [7:0]  hstep;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PALETTE_SIZE; i++) begin
            color_ff[i] <= COLOR_RESET[i];
         end
         mode_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index < CSR_MODE) begin
            color_ff[csr_index] <= csr_wdata;
         end else if (csr_index == CSR_MODE) begin
            mode_ff <= csr_wdata[MODE_W-1:0];
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_data_ff <= req_data;
      end
   end

   // position and phase to palette segment and blend fraction
   always_comb begin
      phase_red   = (in_data_ff.phase >= PHASE_SPAN) ? (in_data_ff.phase - PHASE_SPAN)
                                                    : in_data_ff.phase;
      phase_eff   = mode_ff[MODE_REVERSE] ? (PHASE_LAST - phase_red) : phase_red;
      pos_eff     = mode_ff[MODE_MIRROR] ? ~in_data_ff.position : in_data_ff.position;
      radial_prod = 19'(pos_eff) * RADIAL_NUM;
      scaled      = mode_ff[MODE_RADIAL] ? radial_prod[18:8]
                                         : (11'(pos_eff) * 11'd6);
      sum         = 12'(phase_eff) + 12'(scaled);
      seg         = sum[11:8];
      k1          = (seg >= SEG_WRAP) ? 3'(seg - SEG_WRAP) : seg[2:0];
      k2          = (k1 == LAST_ENTRY) ? 3'd0 : (k1 + 3'd1);
      frac        = sum[7:0];
   end

   // blend the two entries
   always_comb begin
      e1 = color_ff[k1];
      e2 = color_ff[k2];
      h1 = e1[23:16];
      s1 = e1[15:8];
      v1 = e1[7:0];
      h2 = e2[23:16];
      s2 = e2[15:8];
      v2 = e2[7:0];

      // neutral hue: black or gray entries take the other entry's hue
      h2_a = (v2 == 8'd0) ? h1 : h2;
      h1_a = (v1 == 8'd0) ? h2_a : h1;
      h2_b = (s2 == 8'd0) ? h1_a : h2_a;
      h1_b = (s1 == 8'd0) ? h2_b : h1_a;

      // shortest way round the hue circle, truncated toward zero
      hdiff = h2_b - h1_b;
      hneg  = hdiff[7];
      hmag  = hneg ? (8'd0 - hdiff) : hdiff;
      hstep = div255(16'(hmag) * 16'(frac));

      out_data_in.hue = hneg ? (h1_b - hstep) : (h1_b + hstep);
      out_data_in.sat = lerp_toward(s1, s2, frac);
      out_data_in.val = lerp_toward(v1, v2, frac);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_data   = out_data_ff;

`ifndef SYNTHESIS
   a_strobe_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result beat without an accepted request two cycles earlier");

   a_accept_gives_strobe: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |=> rsp_strobe)
      else $error("accepted request produced no result beat");

   a_zero_frac_sat: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && frac == 8'd0) |=> (rsp_data.sat == $past(s1)))
      else $error("saturation moved off the first entry at zero fraction");

   a_zero_frac_hue: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && frac == 8'd0) |=> (rsp_data.hue == $past(h1_b)))
      else $error("hue moved off the first entry at zero fraction");
`endif

endmodule

// ===== verif/hpgs_shade_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV palette gradient shader checker
// Tracks the palette and mode registers from the csr channel, predicts the
// blended color of every accepted pixel and compares each strobed result
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module hpgs_shade_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  hpgs_pkg::req_type                    req_data,
   input  logic                                 rsp_strobe,
   input  hpgs_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [hpgs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hpgs_pkg::COLOR_W-1:0]         csr_wdata,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   checked
);
   import hpgs_pkg::*;

   localparam int FRAC_FULL    = 255;
   localparam int SEG_SPAN     = 256;
   localparam int PLAIN_SCALE  = 6;
   localparam int POS_MAX      = 255;

   logic [COLOR_W-1:0] palette [PALETTE_SIZE];
   logic [MODE_W-1:0]  mode_q;
   rsp_type            expected_colors [$];

   // move a toward b by frac/255 of the gap, truncated
   function automatic logic [7:0] approach(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] frac);
      int ia;
      int ib;
      int fi;
      ia = a;
      ib = b;
      fi = frac;
      if (ib > ia)
         return 8'(ia + ((ib - ia) * fi) / FRAC_FULL);
      return 8'(ia - ((ia - ib) * fi) / FRAC_FULL);
   endfunction

   function automatic rsp_type blend_pixel(input req_type px);
      int               ph;
      int               pos;
      int               scaled;
      int               sum;
      int               seg;
      int               diff;
      int               step;
      logic [7:0]       frac;
      logic [7:0]       hue_gap;
      logic [7:0]       h1, s1, v1, h2, s2, v2;
      rsp_type          color;
      ph = int'(px.phase);
      if (ph >= int'(PHASE_SPAN))
         ph -= int'(PHASE_SPAN);
      if (mode_q[MODE_REVERSE])
         ph = int'(PHASE_LAST) - ph;
      pos = int'(px.position);
      if (mode_q[MODE_MIRROR])
         pos = POS_MAX - pos;
      if (mode_q[MODE_RADIAL])
         scaled = (pos * int'(RADIAL_NUM)) / SEG_SPAN;
      else
         scaled = pos * PLAIN_SCALE;
      sum  = ph + scaled;
      seg  = (sum / SEG_SPAN) % PALETTE_SIZE;
      frac = 8'(sum);
      {h1, s1, v1} = palette[seg];
      {h2, s2, v2} = palette[(seg + 1) % PALETTE_SIZE];
      // dark or gray entries carry no hue: borrow the neighbor's
      if (v2 == 8'd0) h2 = h1;
      if (v1 == 8'd0) h1 = h2;
      if (s2 == 8'd0) h2 = h1;
      if (s1 == 8'd0) h1 = h2;
      // shortest way round the hue circle, quotient toward zero
      hue_gap   = h2 - h1;
      diff      = int'($signed(hue_gap));
      step      = (diff * int'(frac)) / FRAC_FULL;
      color.hue = h1 + 8'(step);
      color.sat = approach(s1, s2, frac);
      color.val = approach(v1, v2, frac);
      return color;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_colors.delete();
         for (int i = 0; i < PALETTE_SIZE; i++)
            palette[i] = COLOR_RESET[i];
         mode_q     = '0;
         fail_count = 0;
         checked    = 0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (expected_colors.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with nothing expected, expected none, got %h",
                        $time, rsp_data);
            end else begin
               want = expected_colors.pop_front();
               compare_field("hue", want.hue, rsp_data.hue);
               compare_field("sat", want.sat, rsp_data.sat);
               compare_field("val", want.val, rsp_data.val);
               checked++;
            end
         end else if (rsp_strobe !== 1'b0) begin
            fail_count++;
            $display("%0t: rsp_strobe unknown, expected 0 or 1, got %b", $time, rsp_strobe);
         end
         if (start === 1'b1 && busy === 1'b0)
            expected_colors.push_back(blend_pixel(req_data));
         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            if (int'(csr_index) < PALETTE_SIZE)
               palette[csr_index] = csr_wdata;
            else if (csr_index == CSR_MODE)
               mode_q = csr_wdata[MODE_W-1:0];
         end
      end
      pending = expected_colors.size();
   end

endmodule

// ===== verif/hsv_palette_gradient_shader_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV palette gradient shader testbench
// Drives directed and random pixels through the shader under a series of
// palette and mode settings, with random gaps between beats; the checker
// beside the block predicts every color and reports the failure count.
// ----------------------------------------------------------------------------
module hsv_palette_gradient_shader_top_tb;
   import hpgs_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = CSR_MODE + 1'b1;
   localparam int RANDOM_ROUNDS   = 8;
   localparam int ROUND_PIXELS    = 55;
   localparam int EXTREME_PIXELS  = 40;
   localparam int DRAIN_CYCLES    = 4;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COLOR_W-1:0]     csr_wdata;

   int                     fail_count;
   int                     pending;
   int                     checked;
   int                     pixels_sent;
   int                     settings_applied;
   logic [COLOR_W-1:0]     palette_next [PALETTE_SIZE];

   hsv_palette_gradient_shader_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   hpgs_shade_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_gap(input bit burst);
      int roll;
      if (burst)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [10:0] pick_phase();
      if ($urandom_range(0, 7) == 0)
         return 11'($urandom_range(int'(PHASE_SPAN), 2047));
      return 11'($urandom_range(0, int'(PHASE_LAST)));
   endfunction

   // called at a falling edge; returns at a falling edge with start left high
   // unless a gap follows
   task automatic send_pixel(input logic [7:0] pos, input logic [10:0] ph, input int gap);
      req_type px;
      px.position = pos;
      px.phase    = ph;
      req_data <= px;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
      pixels_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [COLOR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
   endtask

   // write the whole palette and the mode in one stretch of beats
   task automatic load_settings(input logic [MODE_W-1:0] mode, input bit poke_unused);
      for (int i = 0; i < PALETTE_SIZE; i++)
         csr_write(CSR_INDEX_W'(i), palette_next[i]);
      // junk in the upper bits must be dropped
      csr_write(CSR_MODE, {21'($urandom), mode});
      if (poke_unused)
         csr_write(CSR_UNUSED, 24'($urandom));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      bit burst;
      reset            = 1'b1;
      start            = 1'b0;
      req_data         = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      pixels_sent      = 0;
      settings_applied = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset rainbow: field extremes, wrap of the phase, segment borders
      send_pixel(8'd0,   11'd0,    idle_gap(0));
      send_pixel(8'd255, 11'd0,    idle_gap(0));
      send_pixel(8'd0,   11'd1535, idle_gap(0));
      send_pixel(8'd255, 11'd1535, idle_gap(0));
      send_pixel(8'd0,   11'd1536, idle_gap(0));
      send_pixel(8'd255, 11'd2047, idle_gap(0));
      send_pixel(8'd128, 11'd255,  idle_gap(0));
      send_pixel(8'd128, 11'd256,  idle_gap(0));
      settle();

      // dark and gray entries, a half-turn hue step, an all-zero entry
      palette_next = '{24'h10FFFF, 24'h108000, 24'h9000FF,
                       24'h10FFFF, 24'h000000, 24'h90FF80};
      load_settings(3'b000, 1'b0);
      for (int k = 0; k < PALETTE_SIZE; k++) begin
         send_pixel(8'd0, 11'(k * 256 + 128), idle_gap(0));
         send_pixel(8'd0, 11'(k * 256 + 255), idle_gap(0));
      end
      settle();

      // every mode bit at once
      load_settings(3'b111, 1'b0);
      send_pixel(8'd0,   11'd0,    idle_gap(0));
      send_pixel(8'd255, 11'd2047, idle_gap(0));
      send_pixel(8'd200, 11'd1000, idle_gap(0));
      send_pixel(8'd1,   11'd1,    idle_gap(0));
      settle();

      // register extremes: all clear, then full and clear entries interleaved
      for (int i = 0; i < PALETTE_SIZE; i++)
         palette_next[i] = '0;
      load_settings(3'b000, 1'b0);
      for (int n = 0; n < EXTREME_PIXELS; n++)
         send_pixel(8'($urandom), pick_phase(), idle_gap(0));
      settle();

      for (int i = 0; i < PALETTE_SIZE; i++)
         palette_next[i] = (i % 2 == 0) ? 24'hFFFFFF : 24'h000000;
      load_settings(3'b111, 1'b0);
      for (int n = 0; n < EXTREME_PIXELS; n++)
         send_pixel(8'($urandom), pick_phase(), idle_gap(0));
      settle();

      // random palettes, one round per mode value
      for (int r = 0; r < RANDOM_ROUNDS; r++) begin
         for (int i = 0; i < PALETTE_SIZE; i++)
            palette_next[i] = {8'($urandom), pick_byte(), pick_byte()};
         load_settings(MODE_W'(r), r == 3);
         burst = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < ROUND_PIXELS; n++)
            send_pixel(8'($urandom), pick_phase(), idle_gap(burst));
         settle();
      end

      $display("Sent %0d pixels under %0d palette and mode settings, %0d results compared",
               pixels_sent, settings_applied, checked);
      $display("Covered all mode combinations, neutral hues, hue wrap and phase overflow");
      if (fail_count == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d results still expected", pending);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
